// ----- rtl/core/tws_pkg.sv -----
// Package for the trie word store: item and result structs, command codes,
// control and status structs shared by the controller and datapath.
// No dependencies.
`default_nettype none

package tws_pkg;

	localparam int NODE_COUNT_DEF    = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;
	localparam int LETTER_W          = 5;
	localparam int CMD_W             = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WORD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [LETTER_W-1:0] letter;
		logic                last_letter;
	} tws_item_t;

	typedef struct packed {
		logic found;
		logic pool_full;
	} tws_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic issue;
		logic lookup;
	} tws_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
	} tws_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/trie_word_store.sv -----
// Trie word store: one letter per item, a result on the last letter of a word.
// The result strobe is registered from the lookup state that follows the accepting edge.
// A new letter is not taken until the lookup of the last one is done, as the child table read is registered.
// Reset: the child table is swept to zero, with busy high during the sweep.
// The result receiver cannot stall; done lasts exactly one cycle per word.
`default_nettype none

module trie_word_store
	import tws_pkg::*;
#(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire tws_item_t item,
	output logic           done,
	output tws_result_t    result
);

	tws_ctl_t ctl;
	tws_sts_t sts;

	tws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.sts    (sts)
	);

	tws_datapath #(
		.NODE_COUNT    (NODE_COUNT),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Only one of clearing, issuing a read and resolving a lookup at a time.
	a_ctl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.clear, ctl.issue, ctl.lookup}))
		else $error("controller commands overlap");

	// A transfer is always followed by a lookup cycle with busy high.
	a_issue_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |=> ctl.lookup && busy)
		else $error("accepted letter not resolved in the next cycle");

	// A result strobe only follows a lookup cycle.
	a_done_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl.lookup))
		else $error("result without a lookup");

	// A result never reports both found and pool full.
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.found && result.pool_full))
		else $error("found and pool_full together");

endmodule

`default_nettype wire

// ----- rtl/core/tws_ctrl.sv -----
// Controller for the trie word store: clearing pass, accept and lookup states.
// Depends on tws_pkg.
`default_nettype none

module tws_ctrl
	import tws_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output tws_ctl_t      ctl,
	input  wire tws_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} tws_state_t;

	tws_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign ctl.clear  = (state_q == ST_CLEAR);
	assign ctl.issue  = (state_q == ST_IDLE) && start;
	assign ctl.lookup = (state_q == ST_LOOKUP);

endmodule

`default_nettype wire

// ----- rtl/core/tws_datapath.sv -----
// Datapath for the trie word store: child table memory, walk registers,
// node allocator, clearing sweep and result register. Depends on tws_pkg.
`default_nettype none

module tws_datapath
	import tws_pkg::*;
#(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tws_ctl_t  ctl,
	output tws_sts_t       sts,
	input  wire tws_item_t item,
	output logic           done,
	output tws_result_t    result
);

	localparam int NODE_W  = $clog2(NODE_COUNT);
	localparam int FREE_W  = $clog2(NODE_COUNT + 1);
	localparam int DEPTH   = NODE_COUNT * ALPHABET_SIZE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int ALPH_W  = $clog2(ALPHABET_SIZE + 1);
	localparam int LCMP_W  = (LETTER_W > ALPH_W) ? LETTER_W : ALPH_W;

	// Each entry holds the child pointer and the word-end mark of that child.
	// Every node other than the root has exactly one parent entry, and the
	// root can never end a word, so the mark lives with the pointer.
	logic [NODE_W:0] mem [DEPTH];

	logic [ADDR_W-1:0]   clr_q;
	logic [NODE_W-1:0]   cur_q;
	logic                fail_q;
	logic [FREE_W-1:0]   nfree_q;
	logic [CMD_W-1:0]    cmd_q;
	logic                last_q;
	logic                skip_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [NODE_W:0]     rdata_q;
	logic                done_q;
	tws_result_t         result_q;

	logic [ADDR_W-1:0]   addr;
	logic                in_range;
	logic                is_ins;
	logic [NODE_W-1:0]   child_raw;
	logic                end_raw;
	logic                alloc;
	logic [NODE_W-1:0]   child;
	logic                child_ok;
	logic                fail_new;
	logic                mark;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [NODE_W:0]     wdata;
	tws_result_t         result_d;

	assign addr     = ADDR_W'(ADDR_W'(cur_q) * ADDR_W'(ALPHABET_SIZE)) + ADDR_W'(item.letter);
	assign in_range = LCMP_W'(item.letter) < LCMP_W'(ALPHABET_SIZE);

	assign is_ins    = (cmd_q == CMD_INSERT);
	assign child_raw = rdata_q[NODE_W-1:0];
	assign end_raw   = rdata_q[NODE_W];
	assign alloc     = !skip_q && is_ins && (child_raw == '0)
	                   && (nfree_q < FREE_W'(NODE_COUNT));
	assign child     = alloc ? NODE_W'(nfree_q) : child_raw;
	assign child_ok  = (child != '0) && ((NODE_W+1)'(child) < (NODE_W+1)'(NODE_COUNT));
	assign fail_new  = skip_q || !child_ok;
	assign mark      = is_ins && last_q && !fail_new;

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = {mark | end_raw, child};
		if (ctl.clear) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (ctl.lookup && !skip_q && (alloc || mark)) begin
			we = 1'b1;
		end
	end

	always_comb begin
		result_d.found     = 1'b0;
		result_d.pool_full = 1'b0;
		case (cmd_q)
			CMD_INSERT: result_d.pool_full = fail_new;
			CMD_WORD:   result_d.found     = !fail_new && end_raw;
			default:    result_d.found     = !fail_new;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.issue) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			cmd_q  <= item.cmd;
			last_q <= item.last_letter;
			skip_q <= fail_q || !in_range;
			addr_q <= addr;
		end
		if (ctl.lookup) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			cur_q   <= '0;
			fail_q  <= 1'b0;
			nfree_q <= FREE_W'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.lookup && last_q;
			if (ctl.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (ctl.lookup) begin
				if (alloc) begin
					nfree_q <= nfree_q + FREE_W'(1);
				end
				// A finished word sends the walk back to the root.
				if (last_q) begin
					cur_q  <= '0;
					fail_q <= 1'b0;
				end else begin
					if (!fail_new) cur_q <= child;
					fail_q <= fail_new;
				end
			end
		end
	end

	assign sts.clear_done = (clr_q == ADDR_W'(DEPTH - 1));
	assign done           = done_q;
	assign result         = result_q;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for trie_word_store: random and directed words drive insert and search walks,
// and a behavioral trie checks each found / pool_full result in order.
// Depends on tws_pkg and the trie_word_store RTL.

module tb;
	import tws_pkg::*;

	localparam int NODES       = NODE_COUNT_DEF;
	localparam int LETTERS     = ALPHABET_SIZE_DEF;
	localparam int NODE_W      = $clog2(NODES);
	localparam int IDLE_LIMIT  = 100000;
	localparam int TAIL_CYCLES = 10;
	localparam int MAX_PRINTS  = 100;
	localparam int VOCAB_MAX   = 256;
	localparam int WORD_MAX    = 16;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic      drain;
		tws_item_t it;
	} send_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	tws_item_t   item = '0;
	logic        busy;
	logic        done;
	tws_result_t result;

	trie_word_store uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow trie, updated in transfer order.
	bit [NODE_W-1:0] child_of [NODES*LETTERS];
	bit              word_end [NODES];
	int              free_node = 1;
	int              walk_node = 0;
	bit              walk_dead = 1'b0;

	tws_result_t     verdicts[$];
	send_t           sendq[$];
	int              fails = 0;
	logic            took = 1'b0;
	int              burst_left = 8;
	int              gap_left = 0;
	int              stuck = 0;

	// Word under construction, and the words inserted so far.
	bit [4:0]        spell [WORD_MAX];
	int              spell_len;
	bit [4:0]        vocab [VOCAB_MAX][WORD_MAX];
	int              vocab_len [VOCAB_MAX];
	int              vocab_n = 0;

	function automatic bit trie_step(input tws_item_t it, output tws_result_t res);
		int slot;
		int kid;
		bit ins;
		ins = (it.cmd == CMD_INSERT);
		res = '0;
		if (!walk_dead) begin
			if (int'(it.letter) >= LETTERS) begin
				walk_dead = 1'b1;
			end else begin
				slot = walk_node * LETTERS + int'(it.letter);
				kid = int'(child_of[slot]);
				if (kid == 0 && ins && free_node < NODES) begin
					kid = free_node;
					child_of[slot] = NODE_W'(kid);
					free_node++;
				end
				if (kid == 0)
					walk_dead = 1'b1;
				else
					walk_node = kid;
			end
		end
		if (!it.last_letter)
			return 1'b0;
		if (ins) begin
			if (walk_dead)
				res.pool_full = 1'b1;
			else
				word_end[walk_node] = 1'b1;
		end else if (it.cmd == CMD_WORD) begin
			res.found = !walk_dead && word_end[walk_node];
		end else begin
			// The spare command code behaves as a prefix search.
			res.found = !walk_dead;
		end
		walk_node = 0;
		walk_dead = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		fails++;
		if (fails <= MAX_PRINTS)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	task automatic put(input logic [CMD_W-1:0] cmd, input int letter, input bit last);
		send_t s;
		s.drain = 1'b0;
		s.it.cmd = cmd;
		s.it.letter = letter[LETTER_W-1:0];
		s.it.last_letter = last;
		sendq.push_back(s);
	endtask

	// Queues the spelled word; mix_pct is the chance that a letter before the
	// last one carries a random command of its own.
	task automatic queue_word(input logic [CMD_W-1:0] cmd, input int mix_pct, input bit drain);
		logic [CMD_W-1:0] c;
		for (int i = 0; i < spell_len; i++) begin
			c = cmd;
			if (i != spell_len - 1 && $urandom_range(99) < mix_pct)
				c = CMD_W'($urandom_range(3));
			put(c, int'(spell[i]), i == spell_len - 1);
			if (i == 0 && drain)
				sendq[sendq.size()-1].drain = 1'b1;
		end
	endtask

	task automatic make_word(input int min_len, input int max_len, input int top_letter);
		spell_len = $urandom_range(max_len, min_len);
		for (int i = 0; i < spell_len; i++)
			spell[i] = LETTER_W'($urandom_range(top_letter));
	endtask

	task automatic recall_word(input bit cut);
		int k;
		k = $urandom_range(vocab_n - 1);
		spell_len = vocab_len[k];
		for (int i = 0; i < spell_len; i++)
			spell[i] = vocab[k][i];
		if (cut)
			spell_len = $urandom_range(spell_len, 1);
	endtask

	task automatic fresh_word();
		if ($urandom_range(99) < 70)
			make_word(1, 6, 5);
		else
			make_word(1, 6, LETTERS - 1);
	endtask

	task automatic queue_mixed(input int count, input bit drain);
		int stop;
		int r;
		bit first;
		stop = sendq.size() + count;
		first = drain;
		while (sendq.size() < stop) begin
			r = $urandom_range(99);
			if (r < 35) begin
				if (vocab_n != 0 && $urandom_range(99) < 20) begin
					recall_word(1'b0);
				end else begin
					fresh_word();
					if (vocab_n < VOCAB_MAX) begin
						for (int i = 0; i < spell_len; i++)
							vocab[vocab_n][i] = spell[i];
						vocab_len[vocab_n] = spell_len;
						vocab_n++;
					end
				end
				queue_word(CMD_INSERT, 0, first);
			end else if (r < 60) begin
				if (vocab_n != 0 && $urandom_range(99) < 75)
					recall_word($urandom_range(99) < 25);
				else
					fresh_word();
				queue_word(CMD_WORD, 0, first);
			end else if (r < 85) begin
				if (vocab_n != 0 && $urandom_range(99) < 75)
					recall_word(1'b1);
				else
					fresh_word();
				queue_word(CMD_PREFIX, 0, first);
			end else if (r < 90) begin
				fresh_word();
				queue_word(CMD_SPARE, 0, first);
			end else begin
				// Noise: letters past z and commands that change within the word.
				make_word(1, 5, 31);
				queue_word(CMD_W'($urandom_range(3)), 60, first);
			end
			first = 1'b0;
		end
	endtask

	always @(negedge clk) begin : driver
		send_t     nxt;
		logic      go;
		tws_item_t pick;
		go = start;
		pick = item;
		if (arst_n && (!start || took)) begin
			go = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (sendq.size() != 0 && !(sendq[0].drain && verdicts.size() != 0)) begin
				nxt = sendq.pop_front();
				pick = nxt.it;
				go = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					if ($urandom_range(5) == 0)
						burst_left = $urandom_range(120, 40);
					else
						burst_left = $urandom_range(20, 1);
					gap_left = $urandom_range(8);
				end
			end
		end
		start <= go;
		item <= pick;
	end

	always @(posedge clk) begin : monitor
		tws_result_t want;
		tws_result_t guess;
		if (arst_n) begin
			if (done) begin
				if (verdicts.size() == 0) begin
					report_mismatch($sformatf("result %b with no transfer pending", result));
				end else begin
					want = verdicts.pop_front();
					if (result.found !== want.found)
						report_mismatch($sformatf("found %b, want %b",
							result.found, want.found));
					if (result.pool_full !== want.pool_full)
						report_mismatch($sformatf("pool_full %b, want %b",
							result.pool_full, want.pool_full));
				end
			end
			if (start && !busy) begin
				if (trie_step(item, guess))
					verdicts.push_back(guess);
			end
			took <= start && !busy;
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if (done || (start && !busy))
				stuck = 0;
			else
				stuck++;
			if (stuck >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int stop;
		// Directed words against a nearly empty trie.
		put(CMD_WORD, 0, 1'b1);
		put(CMD_INSERT, 0, 1'b1);
		put(CMD_WORD, 0, 1'b1);
		put(CMD_PREFIX, 0, 1'b1);
		put(CMD_INSERT, 25, 1'b0);
		put(CMD_INSERT, 25, 1'b1);
		put(CMD_WORD, 25, 1'b1);
		put(CMD_PREFIX, 25, 1'b1);
		put(CMD_INSERT, 31, 1'b1);
		put(CMD_WORD, 26, 1'b1);
		put(CMD_INSERT, 0, 1'b0);
		put(CMD_INSERT, 30, 1'b0);
		put(CMD_INSERT, 1, 1'b1);
		put(CMD_SPARE, 25, 1'b0);
		put(CMD_SPARE, 25, 1'b1);
		put(CMD_INSERT, 3, 1'b0);
		put(CMD_WORD, 4, 1'b1);
		put(CMD_WORD, 3, 1'b0);
		put(CMD_INSERT, 4, 1'b1);
		put(CMD_WORD, 3, 1'b0);
		put(CMD_WORD, 4, 1'b1);
		put(CMD_INSERT, 0, 1'b1);
		put(CMD_WORD, 16, 1'b1);

		queue_mixed(100, 1'b1);

		// Long random inserts use up the node pool; a few searches ride along.
		stop = sendq.size() + 1150;
		make_word(15, 16, LETTERS - 1);
		queue_word(CMD_INSERT, 0, 1'b1);
		while (sendq.size() < stop) begin
			if ($urandom_range(31) == 0) begin
				recall_word($urandom_range(1) == 1);
				queue_word(CMD_WORD, 0, 1'b0);
			end else begin
				make_word(15, 16, LETTERS - 1);
				queue_word(CMD_INSERT, 0, 1'b0);
			end
		end

		// With the pool full, known words still resolve and new ones fail.
		queue_mixed(100, 1'b1);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (sendq.size() != 0 || start || verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/tws_pkg.sv
rtl/core/tws_ctrl.sv
rtl/core/tws_datapath.sv
rtl/core/trie_word_store.sv
sim/tb.sv
